@@ hdl/biquad_cascade_df1_filter_assert.svh @@
// assertion macros shared by the biquad cascade checkers
`ifndef BIQUAD_CASCADE_DF1_FILTER_ASSERT_SVH
`define BIQUAD_CASCADE_DF1_FILTER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define BQD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("biquad cascade assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define BQD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("biquad cascade assertion failed");

`endif

@@ hdl/bqd_pkg.sv @@
// shared types and codes of the biquad cascade
package bqd_pkg;

   // fixed field widths
   localparam int OP_W   = 2;
   localparam int CHAN_W = 3;
   localparam int SECT_W = 3;
   localparam int CSEL_W = 3;
   localparam int HSEL_W = 2;
   localparam int CNT_W  = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
   localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
   localparam logic [OP_W-1:0] OP_HIST   = 2'd2;

   // coefficient codes, also the order of the multiply steps
   localparam int NUM_COEFS = 5;
   localparam logic [CSEL_W-1:0] COEF_B0 = 3'd0;
   localparam logic [CSEL_W-1:0] COEF_B1 = 3'd1;
   localparam logic [CSEL_W-1:0] COEF_B2 = 3'd2;
   localparam logic [CSEL_W-1:0] COEF_A1 = 3'd3;
   localparam logic [CSEL_W-1:0] COEF_A2 = 3'd4;

   // history word codes
   localparam int NUM_HIST = 4;
   localparam logic [HSEL_W-1:0] HIST_X1 = 2'd0;
   localparam logic [HSEL_W-1:0] HIST_X2 = 2'd1;
   localparam logic [HSEL_W-1:0] HIST_Y1 = 2'd2;
   localparam logic [HSEL_W-1:0] HIST_Y2 = 2'd3;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic mul_sub;
      logic acc_en;
      logic acc_first;
   } mac_ctrl_type;

endpackage

@@ hdl/bqd_ram.sv @@
// generic single-write, single-read memory with registered read data
module bqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH <= 2) ? 1 : $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/bqd_mac.sv @@
// shared multiply-accumulate unit with rounding and saturation
module bqd_mac #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 32
) (
   input  logic                          clock,
   input  bqd_pkg::mac_ctrl_type         ctrl,
   input  logic signed [COEF_BITS-1:0]   coef,
   input  logic signed [SAMPLE_BITS-1:0] data,
   output logic signed [SAMPLE_BITS-1:0] y,
   output logic                          clip
);

   localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int FRAC   = COEF_BITS - 4;
   localparam int SH_W   = ACC_W - FRAC;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     sub_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext, addend, rnd, shifted;
   logic [SH_W-1:0]          sh;
   logic [SH_W-SAMPLE_BITS:0] hi;
   logic                     ovf;

   assign prod_in = coef * data;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         sub_ff  <= ctrl.mul_sub;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      prod_ext = ACC_W'(prod_ff);
      addend   = sub_ff ? -prod_ext : prod_ext;
      acc_in   = (ctrl.acc_first ? '0 : acc_ff) + addend;
   end

   // round half up, drop the fraction, clip to the sample range
   always_comb begin
      rnd     = acc_ff + RND_HALF;
      shifted = rnd >>> FRAC;
      sh      = shifted[SH_W-1:0];
      hi      = sh[SH_W-1:SAMPLE_BITS-1];
      ovf     = !((&hi) || (~|hi));
      clip    = ovf;
      if (ovf) begin
         y = sh[SH_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         y = sh[SAMPLE_BITS-1:0];
      end
   end

endmodule

@@ hdl/biquad_cascade_df1_filter.sv @@
// a filter transaction passes ST_FETCH, then ST_MUL, ST_ACC and ST_WRITE per section, then ST_DONE
// filter transactions do not overlap, the single shared multiplier doing five products per
//    section; coefficient and history writes are taken in ST_IDLE and leave the block idle
// reset: synchronous, active high; afterwards a clearing pass over all 2**(section bits + channel
//    bits) history rows (64 at the defaults) zeroes coefficients and history, req_tready stays low
// the section count register resets to 1 and is writable at any time
module biquad_cascade_df1_filter #(
   parameter int MAX_SECTIONS = 8,
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 24,
   parameter int COEF_BITS    = 32,
   localparam int REQ_RAW     = bqd_pkg::CHAN_W + SAMPLE_BITS + bqd_pkg::SECT_W
                                + bqd_pkg::CSEL_W + COEF_BITS + bqd_pkg::HSEL_W + SAMPLE_BITS,
   localparam int REQ_DATA_W  = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW     = bqd_pkg::CHAN_W + SAMPLE_BITS,
   localparam int RSP_DATA_W  = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // section count register
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bqd_pkg::CNT_W-1:0]   csr_data,    // sections_in_use
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bqd_pkg::OP_W-1:0]    req_tuser,   // operation
   input  logic [REQ_DATA_W-1:0]       req_tdata,   // channel, sample_in, section, coef_select,
                                                    // coef_value, history_select, history_value
   // response stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [0:0]                  rsp_tuser,   // saturated
   output logic [RSP_DATA_W-1:0]       rsp_tdata    // out_channel, sample_out
);

   // field offsets inside req_tdata
   localparam int CH_LO   = 0;
   localparam int SMP_LO  = CH_LO + bqd_pkg::CHAN_W;
   localparam int SEC_LO  = SMP_LO + SAMPLE_BITS;
   localparam int CSEL_LO = SEC_LO + bqd_pkg::SECT_W;
   localparam int CV_LO   = CSEL_LO + bqd_pkg::CSEL_W;
   localparam int HSEL_LO = CV_LO + COEF_BITS;
   localparam int HV_LO   = HSEL_LO + bqd_pkg::HSEL_W;

   // memory geometry: one row per section for coefficients, per section and channel for history
   localparam int SEC_W      = (MAX_SECTIONS <= 2) ? 1 : $clog2(MAX_SECTIONS);
   localparam int CH_W       = (NUM_CHANNELS <= 2) ? 1 : ((NUM_CHANNELS <= 4) ? 2 : 3);
   localparam int HA_W       = SEC_W + CH_W;
   localparam int COEF_DEPTH = 2 ** SEC_W;
   localparam int HIST_DEPTH = 2 ** HA_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // unpacked request fields
   logic [bqd_pkg::OP_W-1:0]     req_op;
   logic [bqd_pkg::CHAN_W-1:0]   req_chan;
   logic [SAMPLE_BITS-1:0]       req_sample;
   logic [bqd_pkg::SECT_W-1:0]   req_sec;
   logic [bqd_pkg::CSEL_W-1:0]   req_csel;
   logic [COEF_BITS-1:0]         req_coef;
   logic [bqd_pkg::HSEL_W-1:0]   req_hsel;
   logic [SAMPLE_BITS-1:0]       req_hval;
   logic [SEC_W-1:0]             req_sec_idx;
   logic                         req_acc, chan_ok, sec_ok;

   // control registers
   logic [2:0]                   state_ff, state_in;
   logic [HA_W-1:0]              clr_cnt_ff, clr_cnt_in;
   logic [bqd_pkg::CNT_W-1:0]    sections_ff, sections_in;
   logic [SEC_W-1:0]             sec_ff, sec_in;
   logic [SEC_W-1:0]             last_ff, last_in;
   logic [bqd_pkg::CSEL_W-1:0]   step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [bqd_pkg::CHAN_W-1:0]   chan_ff, chan_in;
   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic                         clip_ff, clip_in;
   logic [bqd_pkg::CHAN_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic [SAMPLE_BITS-1:0]       rsp_sample_ff, rsp_sample_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   // memory ports
   logic [bqd_pkg::NUM_COEFS-1:0] coef_we;
   logic [SEC_W-1:0]             coef_waddr, coef_raddr;
   logic [COEF_BITS-1:0]         coef_wdata;
   logic [COEF_BITS-1:0]         coef_rd [bqd_pkg::NUM_COEFS];
   logic [bqd_pkg::NUM_HIST-1:0] hist_we;
   logic [HA_W-1:0]              hist_waddr, hist_raddr;
   logic [SAMPLE_BITS-1:0]       hist_wdata [bqd_pkg::NUM_HIST];
   logic [SAMPLE_BITS-1:0]       hist_rd [bqd_pkg::NUM_HIST];
   logic [SEC_W-1:0]             rd_sec;
   logic [SEC_W-1:0]             eff_last;

   // shared arithmetic
   bqd_pkg::mac_ctrl_type        mac_ctrl;
   logic [COEF_BITS-1:0]         coef_op;
   logic [SAMPLE_BITS-1:0]       data_op;
   logic signed [SAMPLE_BITS-1:0] mac_y;
   logic                         mac_clip;
   logic                         rsp_free;

   // request field split
   assign req_op      = req_tuser;
   assign req_chan    = req_tdata[CH_LO   +: bqd_pkg::CHAN_W];
   assign req_sample  = req_tdata[SMP_LO  +: SAMPLE_BITS];
   assign req_sec     = req_tdata[SEC_LO  +: bqd_pkg::SECT_W];
   assign req_csel    = req_tdata[CSEL_LO +: bqd_pkg::CSEL_W];
   assign req_coef    = req_tdata[CV_LO   +: COEF_BITS];
   assign req_hsel    = req_tdata[HSEL_LO +: bqd_pkg::HSEL_W];
   assign req_hval    = req_tdata[HV_LO   +: SAMPLE_BITS];
   assign req_sec_idx = SEC_W'(req_sec);

   // items for channels or sections that do not exist are dropped
   assign chan_ok = int'(req_chan) < NUM_CHANNELS;
   assign sec_ok  = int'(req_sec) < MAX_SECTIONS;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // register value 0 acts as one section, values above the maximum as the maximum
   always_comb begin
      priority if (sections_ff == '0) begin
         eff_last = '0;
      end else if (int'(sections_ff) > MAX_SECTIONS) begin
         eff_last = SEC_W'(MAX_SECTIONS - 1);
      end else begin
         eff_last = SEC_W'(sections_ff - bqd_pkg::CNT_W'(1));
      end
   end

   // read address moves on to the next section during write-back
   assign rd_sec     = (state_ff == ST_WRITE) ? sec_ff + SEC_W'(1) : sec_ff;
   assign coef_raddr = rd_sec;
   assign hist_raddr = {rd_sec, chan_ff[CH_W-1:0]};

   // coefficient memories, one per coefficient
   for (genvar i = 0; i < bqd_pkg::NUM_COEFS; i++) begin : g_coef
      bqd_ram #(
         .WIDTH (COEF_BITS),
         .DEPTH (COEF_DEPTH)
      ) u_coef_ram (
         .clock (clock),
         .we    (coef_we[i]),
         .waddr (coef_waddr),
         .wdata (coef_wdata),
         .raddr (coef_raddr),
         .rdata (coef_rd[i])
      );
   end

   // history memories, one per history word
   for (genvar i = 0; i < bqd_pkg::NUM_HIST; i++) begin : g_hist
      bqd_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (HIST_DEPTH)
      ) u_hist_ram (
         .clock (clock),
         .we    (hist_we[i]),
         .waddr (hist_waddr),
         .wdata (hist_wdata[i]),
         .raddr (hist_raddr),
         .rdata (hist_rd[i])
      );
   end

   // memory writes: clearing pass, register-style writes, history shift at section end
   always_comb begin
      coef_we    = '0;
      coef_waddr = req_sec_idx;
      coef_wdata = req_coef;
      hist_we    = '0;
      hist_waddr = {req_sec_idx, req_chan[CH_W-1:0]};
      for (int i = 0; i < bqd_pkg::NUM_HIST; i++) begin
         hist_wdata[i] = req_hval;
      end
      priority if (state_ff == ST_CLEAR) begin
         coef_we    = {bqd_pkg::NUM_COEFS{clr_cnt_ff[HA_W-1:SEC_W] == '0}};
         coef_waddr = clr_cnt_ff[SEC_W-1:0];
         coef_wdata = '0;
         hist_we    = '1;
         hist_waddr = clr_cnt_ff;
         for (int i = 0; i < bqd_pkg::NUM_HIST; i++) begin
            hist_wdata[i] = '0;
         end
      end else if (req_acc) begin
         if (req_op == bqd_pkg::OP_COEF && chan_ok && sec_ok && req_csel <= bqd_pkg::COEF_A2) begin
            coef_we[req_csel] = 1'b1;
         end
         if (req_op == bqd_pkg::OP_HIST && chan_ok && sec_ok) begin
            hist_we[req_hsel] = 1'b1;
         end
      end else if (state_ff == ST_WRITE) begin
         // x history takes the section input, y history the section output
         hist_we                      = '1;
         hist_waddr                   = {sec_ff, chan_ff[CH_W-1:0]};
         hist_wdata[bqd_pkg::HIST_X1] = val_ff;
         hist_wdata[bqd_pkg::HIST_X2] = hist_rd[bqd_pkg::HIST_X1];
         hist_wdata[bqd_pkg::HIST_Y1] = mac_y;
         hist_wdata[bqd_pkg::HIST_Y2] = hist_rd[bqd_pkg::HIST_Y1];
      end else begin
         hist_we = '0;
      end
   end

   // operand pair for the current multiply step
   always_comb begin
      unique case (step_ff)
         bqd_pkg::COEF_B0: begin
            coef_op = coef_rd[bqd_pkg::COEF_B0];
            data_op = val_ff;
         end
         bqd_pkg::COEF_B1: begin
            coef_op = coef_rd[bqd_pkg::COEF_B1];
            data_op = hist_rd[bqd_pkg::HIST_X1];
         end
         bqd_pkg::COEF_B2: begin
            coef_op = coef_rd[bqd_pkg::COEF_B2];
            data_op = hist_rd[bqd_pkg::HIST_X2];
         end
         bqd_pkg::COEF_A1: begin
            coef_op = coef_rd[bqd_pkg::COEF_A1];
            data_op = hist_rd[bqd_pkg::HIST_Y1];
         end
         bqd_pkg::COEF_A2: begin
            coef_op = coef_rd[bqd_pkg::COEF_A2];
            data_op = hist_rd[bqd_pkg::HIST_Y2];
         end
         default: begin
            coef_op = '0;
            data_op = '0;
         end
      endcase
   end

   // feedback terms are subtracted; the accumulator adds each product in the cycle after it is registered
   always_comb begin
      mac_ctrl.mul_en    = (state_ff == ST_MUL);
      mac_ctrl.mul_sub   = (step_ff == bqd_pkg::COEF_A1) || (step_ff == bqd_pkg::COEF_A2);
      mac_ctrl.acc_en    = (state_ff == ST_MUL && step_ff != bqd_pkg::COEF_B0)
                           || (state_ff == ST_ACC);
      mac_ctrl.acc_first = (state_ff == ST_MUL && step_ff == bqd_pkg::COEF_B1);
   end

   bqd_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (coef_op),
      .data  (data_op),
      .y     (mac_y),
      .clip  (mac_clip)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      sec_in        = sec_ff;
      last_in       = last_ff;
      step_in       = step_ff;
      chan_in       = chan_ff;
      val_in        = val_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_chan_in   = rsp_chan_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      sections_in   = csr_valid ? csr_data : sections_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + HA_W'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc && req_op == bqd_pkg::OP_FILTER && chan_ok) begin
               state_in = ST_FETCH;
               sec_in   = '0;
               last_in  = eff_last;
               chan_in  = req_chan;
               val_in   = req_sample;
               clip_in  = 1'b0;
            end
         end
         ST_FETCH: begin
            state_in = ST_MUL;
            step_in  = bqd_pkg::COEF_B0;
         end
         ST_MUL: begin
            step_in = step_ff + bqd_pkg::CSEL_W'(1);
            if (step_ff == bqd_pkg::COEF_A2) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // section output feeds the next section
            val_in  = mac_y;
            clip_in = clip_ff || mac_clip;
            if (sec_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               step_in  = bqd_pkg::COEF_B0;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // hold here while the previous result is still waiting
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chan_in   = chan_ff;
               rsp_sample_in = val_ff;
               rsp_sat_in    = clip_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         sections_ff  <= bqd_pkg::CNT_W'(1);
         sec_ff       <= '0;
         last_ff      <= '0;
         step_ff      <= bqd_pkg::COEF_B0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         sections_ff  <= sections_in;
         sec_ff       <= sec_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff       <= chan_in;
      val_ff        <= val_in;
      clip_ff       <= clip_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_sample_ff, rsp_chan_ff});

endmodule

@@ hdl/bqd_checker.sv @@
// port-level checker of the biquad cascade and its bind
`include "biquad_cascade_df1_filter_assert.svh"

module bqd_checker #(
   parameter int NUM_CHANNELS = 8,
   parameter int REQ_DATA_W   = 96,
   parameter int RSP_DATA_W   = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [bqd_pkg::OP_W-1:0] req_tuser,
   input logic [REQ_DATA_W-1:0]    req_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [0:0]               rsp_tuser,
   input logic [RSP_DATA_W-1:0]    rsp_tdata
);

   // a stalled result holds its payload
   `BQD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a filter transaction on an existing channel makes the block busy
   `BQD_ASSERT_NEXT(a_busy_after_filter, req_tvalid && req_tready && req_tuser == bqd_pkg::OP_FILTER && int'(req_tdata[bqd_pkg::CHAN_W-1:0]) < NUM_CHANNELS, !req_tready)

   // a new result only comes out of a busy period
   `BQD_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_tvalid), $past(!req_tready))

   // the clearing pass keeps requests out right after reset
   `BQD_ASSERT_NOW(a_clear_after_reset, $fell(reset), !req_tready && !rsp_tvalid)

endmodule

bind biquad_cascade_df1_filter bqd_checker #(
   .NUM_CHANNELS (NUM_CHANNELS),
   .REQ_DATA_W   (REQ_DATA_W),
   .RSP_DATA_W   (RSP_DATA_W)
) u_bqd_checker (.*);
